@@ sv/brs_pkg.sv @@
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants and types of the bilinear image resampler.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;

    localparam int X_W      = $clog2(MAX_WIDTH);
    localparam int Y_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W   = X_W + Y_W;
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W    = 32;
    localparam int SIZE_W   = 9;

    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 16;
    localparam int CNT_W     = $clog2(DIV_NUM_W + 1);
    localparam int RATIO_W   = DIV_NUM_W;
    localparam int FRAC_W    = 16;
    localparam int WGT_W     = 2 * FRAC_W + 1;
    localparam int ACC_W     = WGT_W + 8;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [1:0] REG_SRC_W   = 2'd0;
    localparam logic [1:0] REG_SRC_H   = 2'd1;
    localparam logic [1:0] REG_SCALE   = 2'd2;
    localparam logic [1:0] REG_CHANNEL = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

@@ sv/bilinear_image_resampler.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_resampler
// Source image store with bilinear output pixel computation.
// ----------------------------------------------------------------------------
// A source pixel write uses the single port of the source memory once; an output
// pixel request holds it for four neighbor reads, so writes wait until they end and
// the next request can be taken during the last read. Each result is queued once its
// reads are accumulated; two results can wait at the output. After reset and
// after every register write a shared one-bit-per-cycle divider recomputes the
// output sizes and ratios in four divisions; no beat is taken meanwhile. The source
// memory is not cleared; pixels must be written before they are used.
module bilinear_image_resampler
    import brs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [X_W-1:0]    coord_x,
    input  logic [Y_W-1:0]    coord_y,
    input  logic [PIX_W-1:0]  pixel_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              status,
    output logic [SIZE_W-1:0] output_width,
    output logic [SIZE_W-1:0] output_height
);

    typedef enum logic [4:0] {
        ST_DW  = 5'b00001,
        ST_DH  = 5'b00010,
        ST_RX  = 5'b00100,
        ST_RY  = 5'b01000,
        ST_RUN = 5'b10000
    } cal_state_t;

    cal_state_t state_reg, state_next;
    logic       start_reg, start_next;

    logic [SIZE_W-1:0]  src_w_reg, src_h_reg;
    logic [15:0]        scale_reg;
    logic [2:0]         nch_reg;
    logic [SIZE_W-1:0]  dw_reg, dw_next, dh_reg, dh_next;
    logic [RATIO_W-1:0] ratio_x_reg, ratio_x_next, ratio_y_reg, ratio_y_next;

    logic [SIZE_W-1:0]  sw, sh, sw_m1, sh_m1, q_sat;
    logic [2:0]         nch_eff;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic in_fire, req_fire, wr_fire, out_fire;

    logic              act_reg, act_next;
    logic [1:0]        ph_reg, ph_next;
    logic [1:0]        pend_reg, pend_next;
    logic [X_W-1:0]    xl_reg, xh_reg, xl_c, xh_c;
    logic [Y_W-1:0]    yl_reg, yh_reg, yl_c, yh_c;
    logic [FRAC_W-1:0] fx_reg, fy_reg;
    logic              bad_reg, bad_c;
    logic [31:0]       px_x, px_y;
    logic [FRAC_W:0]   xh_raw, yh_raw;
    logic [FRAC_W:0]   gx, gy;
    logic [WGT_W-1:0]  w_reg [4];

    logic              rd_vld_reg;
    logic [1:0]        rd_idx_reg;
    logic              rd_bad_reg;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_q;
    logic [ACC_W-1:0]  acc_reg [MAX_CHANNELS];
    logic [ACC_W-1:0]  acc_next [MAX_CHANNELS];
    logic [WGT_W-1:0]  w_sel;
    logic [PIX_W-1:0]  pix_c;
    logic [8:0]        vch;

    logic [PIX_W:0]    fifo_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic              push;

    // Derived sizes and divider sequencing.
    always_comb
    begin
        sw = (src_w_reg == '0) ? SIZE_W'(1)
           : ((src_w_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : src_w_reg);
        sh = (src_h_reg == '0) ? SIZE_W'(1)
           : ((src_h_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : src_h_reg);
        sw_m1   = sw - SIZE_W'(1);
        sh_m1   = sh - SIZE_W'(1);
        nch_eff = (nch_reg > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : nch_reg;
        q_sat   = (div_rsp.quo > DIV_NUM_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH)
                : div_rsp.quo[SIZE_W-1:0];

        div_req.start = start_reg;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            ST_DW:
            begin
                div_req.num = DIV_NUM_W'({sw, 8'd0});
                div_req.den = scale_reg;
            end
            ST_DH:
            begin
                div_req.num = DIV_NUM_W'({sh, 8'd0});
                div_req.den = scale_reg;
            end
            ST_RX:
            begin
                div_req.num = {sw_m1[7:0], 16'd0};
                div_req.den = DIV_DEN_W'(dw_reg - SIZE_W'(1));
            end
            ST_RY:
            begin
                div_req.num = {sh_m1[7:0], 16'd0};
                div_req.den = DIV_DEN_W'(dh_reg - SIZE_W'(1));
            end
            ST_RUN:
            begin
                div_req.num = '0;
                div_req.den = '0;
            end
            default:
            begin
                div_req.num = '0;
                div_req.den = '0;
            end
        endcase

        state_next   = state_reg;
        start_next   = 1'b0;
        dw_next      = dw_reg;
        dh_next      = dh_reg;
        ratio_x_next = ratio_x_reg;
        ratio_y_next = ratio_y_reg;
        if (cfg_write)
        begin
            state_next = ST_DW;
            start_next = 1'b1;
        end
        else if (div_rsp.done && !start_reg)
        begin
            unique case (state_reg)
                ST_DW:
                begin
                    dw_next    = q_sat;
                    state_next = ST_DH;
                    start_next = 1'b1;
                end
                ST_DH:
                begin
                    dh_next    = q_sat;
                    state_next = ST_RX;
                    start_next = 1'b1;
                end
                ST_RX:
                begin
                    ratio_x_next = (dw_reg <= SIZE_W'(1)) ? '0 : div_rsp.quo;
                    state_next   = ST_RY;
                    start_next   = 1'b1;
                end
                ST_RY:
                begin
                    ratio_y_next = (dh_reg <= SIZE_W'(1)) ? '0 : div_rsp.quo;
                    state_next   = ST_RUN;
                end
                ST_RUN:
                begin
                    state_next = ST_RUN;
                end
                default:
                begin
                    state_next = ST_DW;
                    start_next = 1'b1;
                end
            endcase
        end
    end

    brs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Input handshake and request setup.
    always_comb
    begin
        if (state_reg != ST_RUN)
        begin
            in_ready = 1'b0;
        end
        else if (op == OP_WRITE)
        begin
            in_ready = !act_reg;
        end
        else
        begin
            in_ready = (!act_reg || ph_reg == 2'd3) && (pend_reg < 2'd2);
        end
        in_fire  = in_valid && in_ready;
        req_fire = in_fire && (op == OP_REQUEST);
        wr_fire  = in_fire && (op == OP_WRITE);
        out_fire = out_valid && out_ready;

        px_x   = 32'(ratio_x_reg) * 32'(coord_x);
        px_y   = 32'(ratio_y_reg) * 32'(coord_y);
        xh_raw = {1'b0, px_x[31:16]} + (FRAC_W+1)'(px_x[15:0] != '0);
        yh_raw = {1'b0, px_y[31:16]} + (FRAC_W+1)'(px_y[15:0] != '0);
        xl_c   = (px_x[31:16] > 16'(sw_m1)) ? sw_m1[X_W-1:0] : px_x[16+X_W-1:16];
        yl_c   = (px_y[31:16] > 16'(sh_m1)) ? sh_m1[Y_W-1:0] : px_y[16+Y_W-1:16];
        xh_c   = (xh_raw > 17'(sw_m1)) ? sw_m1[X_W-1:0] : xh_raw[X_W-1:0];
        yh_c   = (yh_raw > 17'(sh_m1)) ? sh_m1[Y_W-1:0] : yh_raw[Y_W-1:0];
        bad_c  = ({1'b0, coord_x} >= dw_reg) || ({1'b0, coord_y} >= dh_reg);

        act_next = act_reg;
        ph_next  = ph_reg;
        if (req_fire)
        begin
            act_next = 1'b1;
            ph_next  = 2'd0;
        end
        else if (act_reg)
        begin
            ph_next = ph_reg + 2'd1;
            if (ph_reg == 2'd3)
            begin
                act_next = 1'b0;
            end
        end
        pend_next = pend_reg + 2'(req_fire) - 2'(out_fire);

        gx = 17'h10000 - {1'b0, fx_reg};
        gy = 17'h10000 - {1'b0, fy_reg};

        unique case (ph_reg)
            2'd0: ram_addr = {yl_reg, xl_reg};
            2'd1: ram_addr = {yl_reg, xh_reg};
            2'd2: ram_addr = {yh_reg, xl_reg};
            2'd3: ram_addr = {yh_reg, xh_reg};
            default: ram_addr = {yl_reg, xl_reg};
        endcase
        if (wr_fire)
        begin
            ram_addr = {coord_y, coord_x};
        end
    end

    brs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (wr_fire),
        .addr  (ram_addr),
        .wdata (pixel_in),
        .rdata (ram_q)
    );

    // Weighted accumulation of the four neighbors.
    always_comb
    begin
        w_sel = w_reg[rd_idx_reg];
        pix_c = '0;
        vch   = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            acc_next[c] = ((rd_idx_reg == 2'd0) ? '0 : acc_reg[c])
                        + ACC_W'(ram_q[8*c +: 8]) * ACC_W'(w_sel);
            vch = acc_next[c][ACC_W-1:32];
            if (3'(c) < nch_eff && !rd_bad_reg)
            begin
                pix_c[8*c +: 8] = (vch > 9'd255) ? 8'd255 : vch[7:0];
            end
        end
        push = rd_vld_reg && (rd_idx_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_DW;
            start_reg   <= 1'b1;
            src_w_reg   <= SIZE_W'(256);
            src_h_reg   <= SIZE_W'(256);
            scale_reg   <= 16'd512;
            nch_reg     <= 3'd4;
            dw_reg      <= '0;
            dh_reg      <= '0;
            ratio_x_reg <= '0;
            ratio_y_reg <= '0;
            act_reg     <= 1'b0;
            ph_reg      <= 2'd0;
            pend_reg    <= 2'd0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= 2'd0;
            wp_reg      <= 1'b0;
            rp_reg      <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            dw_reg      <= dw_next;
            dh_reg      <= dh_next;
            ratio_x_reg <= ratio_x_next;
            ratio_y_reg <= ratio_y_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SRC_W:   src_w_reg <= cfg_data[SIZE_W-1:0];
                    REG_SRC_H:   src_h_reg <= cfg_data[SIZE_W-1:0];
                    REG_SCALE:   scale_reg <= cfg_data;
                    REG_CHANNEL: nch_reg   <= cfg_data[2:0];
                    default:     nch_reg   <= nch_reg;
                endcase
            end
            act_reg    <= act_next;
            ph_reg     <= ph_next;
            pend_reg   <= pend_next;
            rd_vld_reg <= act_reg;
            rd_idx_reg <= ph_reg;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (out_fire)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            xl_reg  <= xl_c;
            xh_reg  <= xh_c;
            yl_reg  <= yl_c;
            yh_reg  <= yh_c;
            fx_reg  <= px_x[15:0];
            fy_reg  <= px_y[15:0];
            bad_reg <= bad_c;
        end
        if (act_reg && ph_reg == 2'd0)
        begin
            w_reg[0] <= WGT_W'(gx) * WGT_W'(gy);
            w_reg[1] <= WGT_W'(fx_reg) * WGT_W'(gy);
            w_reg[2] <= WGT_W'(gx) * WGT_W'(fy_reg);
            w_reg[3] <= WGT_W'(fx_reg) * WGT_W'(fy_reg);
        end
        rd_bad_reg <= bad_reg;
        if (rd_vld_reg)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                acc_reg[c] <= acc_next[c];
            end
        end
        if (push)
        begin
            fifo_reg[wp_reg] <= {rd_bad_reg, pix_c};
        end
    end

    assign out_valid     = (cnt_reg != 2'd0);
    assign pixel_out     = fifo_reg[rp_reg][PIX_W-1:0];
    assign status        = fifo_reg[rp_reg][PIX_W];
    assign output_width  = dw_reg;
    assign output_height = dh_reg;

endmodule

@@ sv/brs_ram.sv @@
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/brs_div.sv @@
// ----------------------------------------------------------------------------
// brs_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brs_div
    import brs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W+1:0] diff;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            cnt_next  = CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_DEN_W+1])
            begin
                rem_next = diff[DIV_DEN_W-1:0];
            end
            else
            begin
                rem_next = rem_sh[DIV_DEN_W-1:0];
            end
            quo_next = {quo_reg[DIV_NUM_W-2:0], ~diff[DIV_DEN_W+1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ sv/brs_checker.sv @@
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks of the bilinear image resampler.
// ----------------------------------------------------------------------------
module brs_checker
    import brs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [PIX_W-1:0]  pixel_out,
    input logic              status,
    input logic [SIZE_W-1:0] output_width,
    input logic [SIZE_W-1:0] output_height
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out) && $stable(status))
        else $error("output beat changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> pixel_out == '0)
        else $error("rejected request returned a nonzero pixel");

    a_empty_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (output_width == '0 || output_height == '0) |-> status)
        else $error("request accepted for an empty output image");

    a_size_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> output_width <= SIZE_W'(MAX_WIDTH)
                   && output_height <= SIZE_W'(MAX_HEIGHT))
        else $error("output size above the maximum");

endmodule

bind bilinear_image_resampler brs_checker u_brs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_out     (pixel_out),
    .status        (status),
    .output_width  (output_width),
    .output_height (output_height)
);
